>>> hw/rtl/sha256_byte_stream_hasher_unit_macros.svh
// Assertion macros shared by the SHA-256 byte stream hasher RTL.
`ifndef SHA256_BYTE_STREAM_HASHER_UNIT_MACROS_SVH
`define SHA256_BYTE_STREAM_HASHER_UNIT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define SHA_BSH_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset.
`define SHA_BSH_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> hw/rtl/sha_bsh_pkg.sv
// Shared types, constants and helper functions for the SHA-256 byte stream hasher.
`timescale 1ns / 1ps

package sha_bsh_pkg;

  typedef logic [31:0] word_t;
  // Working/chaining set, index 0 is a, index 7 is h
  typedef word_t [7:0] hash_vec_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_COMP_DATA,
    ST_PAD80,
    ST_PADZ,
    ST_LEN,
    ST_COMP_PAD,
    ST_COMP_FINAL,
    ST_OUT
  } top_state_t;

  typedef enum logic [1:0] {
    ENG_IDLE,
    ENG_RUN,
    ENG_FOLD
  } eng_state_t;

  // Control from the sequencer to the compression engine
  typedef struct packed {
    logic        start;
    logic        init;
    logic        byte_en;
    logic [5:0]  byte_addr;
    logic [7:0]  byte_data;
    logic        len_en;
    logic [63:0] bit_len;
  } eng_ctl_t;

  localparam int unsigned PAD_LIMIT  = 56;
  localparam int unsigned BLOCK_LAST = 63;
  localparam logic [7:0]  PAD_BYTE   = 8'h80;

  localparam word_t ROUND_K [0:63] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  localparam word_t INIT_H [0:7] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  // Rotate right by a constant amount
  function automatic word_t rotr(input word_t v, input int unsigned n);
    return (v >> n) | (v << (32 - n));
  endfunction

endpackage

>>> hw/rtl/sha256_byte_stream_hasher_unit.sv
// Top level of the SHA-256 byte stream hasher: byte intake, padding sequencer, digest output.
`timescale 1ns / 1ps
`include "sha256_byte_stream_hasher_unit_macros.svh"

// SHA-256 over a byte stream, one byte per input beat. A beat with has_byte
// appends in_data_byte; a beat with last closes the message (byte first if
// both are set), and the block then returns eight digest beats, word 0 first,
// with out_last_word on word 7, and starts the next message from the initial
// hash. A beat that neither fills the 64-byte block nor closes the message
// leaves in_ready high for the next beat. A beat that fills the block occupies
// it while one shared round unit does one round per cycle over 64 rounds, plus
// load and fold. A last beat runs the padding through the block buffer one byte
// per cycle, one or two compressions and the length write, then holds out_valid
// until the eight digest beats are taken. in_ready is low throughout.
module sha256_byte_stream_hasher_unit (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_data_byte,
  input  logic        in_has_byte,
  input  logic        in_last,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [31:0] out_digest_word,
  output logic [2:0]  out_word_index,
  output logic        out_last_word
);
  import sha_bsh_pkg::*;

  top_state_t state_r, state_nxt;
  logic [6:0]  fill_r, fill_nxt;
  logic [60:0] total_r, total_nxt;
  logic        pend_last_r, pend_last_nxt;
  logic [2:0]  idx_r, idx_nxt;
  logic        in_acc, out_acc;
  logic        block_full;
  logic        fill_at_lim, fill_at_end;
  eng_ctl_t    ctl;
  logic        eng_done;
  hash_vec_t   chain;

  sha_bsh_engine u_engine (
    .clk   (clk),
    .rst_n (rst_n),
    .ctl   (ctl),
    .done  (eng_done),
    .chain (chain)
  );

  assign in_acc      = in_valid & in_ready;
  assign out_acc     = out_valid & out_ready;
  assign block_full  = in_has_byte && (fill_r == 7'(BLOCK_LAST));
  assign fill_at_lim = (fill_r == 7'(PAD_LIMIT));
  assign fill_at_end = (fill_r == 7'(BLOCK_LAST + 1));

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          if (block_full) state_nxt = ST_COMP_DATA;
          else if (in_last) state_nxt = ST_PAD80;
        end
      end
      ST_COMP_DATA: if (eng_done) state_nxt = pend_last_r ? ST_PAD80 : ST_IDLE;
      ST_PAD80:     state_nxt = ST_PADZ;
      ST_PADZ: begin
        if (fill_at_lim) state_nxt = ST_LEN;
        else if (fill_at_end) state_nxt = ST_COMP_PAD;
      end
      ST_LEN:        state_nxt = ST_COMP_FINAL;
      ST_COMP_PAD:   if (eng_done) state_nxt = ST_PADZ;
      ST_COMP_FINAL: if (eng_done) state_nxt = ST_OUT;
      ST_OUT:        if (out_acc && idx_r == 3'd7) state_nxt = ST_IDLE;
      default:       state_nxt = ST_IDLE;
    endcase
  end

  // outputs and engine control
  always_comb begin
    in_ready      = 1'b0;
    out_valid     = 1'b0;
    ctl           = '0;
    ctl.byte_addr = fill_r[5:0];
    ctl.bit_len   = {total_r, 3'b000};
    case (state_r)
      ST_IDLE: begin
        in_ready      = 1'b1;
        ctl.byte_en   = in_acc && in_has_byte;
        ctl.byte_data = in_data_byte;
        ctl.start     = in_acc && block_full;
      end
      ST_PAD80: begin
        ctl.byte_en   = 1'b1;
        ctl.byte_data = PAD_BYTE;
      end
      ST_PADZ: begin
        ctl.byte_en = !fill_at_lim && !fill_at_end;
        ctl.start   = !fill_at_lim && fill_at_end;
      end
      ST_LEN: begin
        ctl.len_en = 1'b1;
        ctl.start  = 1'b1;
      end
      ST_OUT: begin
        out_valid = 1'b1;
        ctl.init  = out_acc && idx_r == 3'd7;
      end
      default: begin
        in_ready  = 1'b0;
        out_valid = 1'b0;
      end
    endcase
  end

  // fill count, byte total, digest index
  always_comb begin
    fill_nxt      = fill_r;
    total_nxt     = total_r;
    pend_last_nxt = pend_last_r;
    idx_nxt       = idx_r;
    if (state_r == ST_IDLE && in_acc) begin
      pend_last_nxt = in_last;
      if (in_has_byte) begin
        fill_nxt  = block_full ? '0 : fill_r + 7'd1;
        total_nxt = total_r + 61'd1;
      end
    end
    if (state_r == ST_PAD80 || (state_r == ST_PADZ && ctl.byte_en)) fill_nxt = fill_r + 7'd1;
    if (state_r == ST_PADZ && ctl.start) fill_nxt = '0;
    if (out_acc) idx_nxt = idx_r + 3'd1;
    if (ctl.init) begin
      fill_nxt  = '0;
      total_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      fill_r      <= '0;
      total_r     <= '0;
      pend_last_r <= 1'b0;
      idx_r       <= '0;
    end else begin
      state_r     <= state_nxt;
      fill_r      <= fill_nxt;
      total_r     <= total_nxt;
      pend_last_r <= pend_last_nxt;
      idx_r       <= idx_nxt;
    end
  end

  // digest beat
  assign out_digest_word = chain[idx_r];
  assign out_word_index  = idx_r;
  assign out_last_word   = (idx_r == 3'd7);

  `SHA_BSH_ASSERT_IMP(a_one_side, clk, rst_n, out_valid, !in_ready, "input taken during digest output")
  `SHA_BSH_ASSERT_IMP(a_idle_fill, clk, rst_n, in_ready, fill_r[6] == 1'b0, "fill count overflow while idle")
  `SHA_BSH_ASSERT_NXT(a_restart, clk, rst_n, out_valid && out_ready && out_last_word, fill_r == 7'd0 && total_r == 61'd0 && idx_r == 3'd0, "state not restarted after digest")
  `SHA_BSH_ASSERT_IMP(a_pad_range, clk, rst_n, state_r == ST_PADZ, fill_r <= 7'd64, "padding past block end")

endmodule

>>> hw/rtl/sha_bsh_round.sv
// One SHA-256 round plus one message schedule step, purely combinational.
`timescale 1ns / 1ps

module sha_bsh_round (
  input  sha_bsh_pkg::hash_vec_t v_in,
  input  sha_bsh_pkg::word_t     k_in,
  input  sha_bsh_pkg::word_t     w_in,
  input  sha_bsh_pkg::word_t     w_m15,
  input  sha_bsh_pkg::word_t     w_m7,
  input  sha_bsh_pkg::word_t     w_m2,
  output sha_bsh_pkg::hash_vec_t v_out,
  output sha_bsh_pkg::word_t     w_new
);
  import sha_bsh_pkg::*;

  word_t big_s1, ch, t1, big_s0, maj, t2;
  word_t sm_s0, sm_s1;

  // compression round
  always_comb begin
    big_s1 = rotr(v_in[4], 6) ^ rotr(v_in[4], 11) ^ rotr(v_in[4], 25);
    ch     = (v_in[4] & v_in[5]) ^ (~v_in[4] & v_in[6]);
    t1     = v_in[7] + big_s1 + ch + k_in + w_in;
    big_s0 = rotr(v_in[0], 2) ^ rotr(v_in[0], 13) ^ rotr(v_in[0], 22);
    maj    = (v_in[0] & v_in[1]) ^ (v_in[0] & v_in[2]) ^ (v_in[1] & v_in[2]);
    t2     = big_s0 + maj;

    v_out[0] = t1 + t2;
    v_out[1] = v_in[0];
    v_out[2] = v_in[1];
    v_out[3] = v_in[2];
    v_out[4] = v_in[3] + t1;
    v_out[5] = v_in[4];
    v_out[6] = v_in[5];
    v_out[7] = v_in[6];
  end

  // schedule word 16 ahead of the current one
  always_comb begin
    sm_s0 = rotr(w_m15, 7) ^ rotr(w_m15, 18) ^ (w_m15 >> 3);
    sm_s1 = rotr(w_m2, 17) ^ rotr(w_m2, 19) ^ (w_m2 >> 10);
    w_new = w_in + sm_s0 + w_m7 + sm_s1;
  end

endmodule

>>> hw/rtl/sha_bsh_engine.sv
// Compression engine: block buffer, working registers, round counter, chaining words.
`timescale 1ns / 1ps
`include "sha256_byte_stream_hasher_unit_macros.svh"

module sha_bsh_engine (
  input  logic                   clk,
  input  logic                   rst_n,
  input  sha_bsh_pkg::eng_ctl_t  ctl,
  output logic                   done,
  output sha_bsh_pkg::hash_vec_t chain
);
  import sha_bsh_pkg::*;

  eng_state_t state_r, state_nxt;
  logic [5:0] round_r, round_nxt;
  hash_vec_t  v_r;
  hash_vec_t  v_round;
  hash_vec_t  chain_r, chain_nxt;
  word_t      w_r [16];
  word_t      w_new;
  logic       run_en;

  // shared round unit
  sha_bsh_round u_round (
    .v_in  (v_r),
    .k_in  (ROUND_K[round_r]),
    .w_in  (w_r[0]),
    .w_m15 (w_r[1]),
    .w_m7  (w_r[9]),
    .w_m2  (w_r[14]),
    .v_out (v_round),
    .w_new (w_new)
  );

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ENG_IDLE: if (ctl.start) state_nxt = ENG_RUN;
      ENG_RUN:  if (round_r == 6'd63) state_nxt = ENG_FOLD;
      ENG_FOLD: state_nxt = ENG_IDLE;
      default:  state_nxt = ENG_IDLE;
    endcase
  end

  // state outputs
  always_comb begin
    done   = 1'b0;
    run_en = 1'b0;
    case (state_r)
      ENG_RUN:  run_en = 1'b1;
      ENG_FOLD: done   = 1'b1;
      default: begin
        done   = 1'b0;
        run_en = 1'b0;
      end
    endcase
  end

  // round counter and chaining words
  always_comb begin
    round_nxt = run_en ? round_r + 6'd1 : '0;
    chain_nxt = chain_r;
    if (ctl.init) begin
      for (int i = 0; i < 8; i++) chain_nxt[i] = INIT_H[i];
    end else if (done) begin
      for (int i = 0; i < 8; i++) chain_nxt[i] = chain_r[i] + v_r[i];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ENG_IDLE;
      round_r <= '0;
      for (int i = 0; i < 8; i++) chain_r[i] <= INIT_H[i];
    end else begin
      state_r <= state_nxt;
      round_r <= round_nxt;
      chain_r <= chain_nxt;
    end
  end

  // working variables
  always_ff @(posedge clk) begin
    if (ctl.start) begin
      v_r <= chain_r;
    end else if (run_en) begin
      v_r <= v_round;
    end
  end

  // block buffer: byte/length writes while idle, schedule window shift while running
  always_ff @(posedge clk) begin
    if (run_en) begin
      for (int i = 0; i < 15; i++) w_r[i] <= w_r[i + 1];
      w_r[15] <= w_new;
    end else begin
      if (ctl.byte_en) begin
        w_r[ctl.byte_addr[5:2]][{~ctl.byte_addr[1:0], 3'b000} +: 8] <= ctl.byte_data;
      end
      if (ctl.len_en) begin
        w_r[14] <= ctl.bit_len[63:32];
        w_r[15] <= ctl.bit_len[31:0];
      end
    end
  end

  assign chain = chain_r;

  `SHA_BSH_ASSERT_IMP(a_start_idle, clk, rst_n, ctl.start, state_r == ENG_IDLE, "start while engine busy")
  `SHA_BSH_ASSERT_IMP(a_no_wr_run, clk, rst_n, ctl.byte_en || ctl.len_en, state_r != ENG_RUN, "buffer write during rounds")
  `SHA_BSH_ASSERT_NXT(a_last_round, clk, rst_n, state_r == ENG_RUN && round_r == 6'd63, state_r == ENG_FOLD, "no fold after last round")
  `SHA_BSH_ASSERT_IMP(a_idle_cnt, clk, rst_n, state_r == ENG_IDLE, round_r == 6'd0, "round count not cleared")

endmodule

>>> test/sha256_byte_stream_hasher_unit_tb.sv
// Self-checking testbench for the SHA-256 byte stream hasher unit.
`timescale 1ns / 1ps

module sha256_byte_stream_hasher_unit_tb;

  localparam int unsigned BLOCK_BYTES  = 64;
  localparam int unsigned LEN_OFFSET   = 56;
  localparam logic [7:0]  PAD_MARK     = 8'h80;
  localparam int unsigned RAND_BEATS   = 410;
  localparam int unsigned QUIET_LIMIT  = 4000;
  localparam int unsigned LONG_HOLD    = 400;
  localparam int unsigned HOLD_AT_WORD = 16;
  localparam int unsigned DRAIN_CYCLES = 100;

  localparam logic [31:0] RK [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  localparam logic [31:0] IV [8] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  // One input beat; drain_first makes the sender wait for all digests
  typedef struct {
    logic [7:0] data;
    logic       has_byte;
    logic       last;
    logic       drain_first;
  } byte_beat_t;

  typedef struct {
    logic [31:0] word;
    logic [2:0]  index;
    logic        last_word;
  } digest_word_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [7:0]  in_data_byte = '0;
  logic        in_has_byte = 1'b0;
  logic        in_last = 1'b0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [31:0] out_digest_word;
  logic [2:0]  out_word_index;
  logic        out_last_word;

  byte_beat_t   beat_q [$];
  digest_word_t digest_q [$];

  // Hash state of the message being absorbed
  logic [31:0] chain_h [8];
  logic [7:0]  blk_bytes [64];
  int unsigned blk_fill;
  logic [60:0] msg_bytes;

  logic        in_beat = 1'b0;
  logic        out_beat = 1'b0;
  int unsigned words_seen = 0;
  int unsigned err_count = 0;
  int unsigned quiet_cycles = 0;
  int unsigned real_beats = 0;
  int unsigned msg_count = 0;

  int          drv_gap = 0;
  int          drv_burst = 0;
  int          rcv_stall = 0;
  int          rcv_burst = 0;
  int          rcv_hold = 0;
  logic        long_hold_done = 1'b0;

  sha256_byte_stream_hasher_unit u_dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_data_byte    (in_data_byte),
    .in_has_byte     (in_has_byte),
    .in_last         (in_last),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_digest_word (out_digest_word),
    .out_word_index  (out_word_index),
    .out_last_word   (out_last_word)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  function automatic logic [31:0] ror32(input logic [31:0] v, input int unsigned n);
    return (v >> n) | (v << (32 - n));
  endfunction

  function automatic void hash_restart();
    int i;
    for (i = 0; i < 8; i++) chain_h[i] = IV[i];
    blk_fill = 0;
    msg_bytes = '0;
  endfunction

  // 64 rounds over the buffered block, folded into the chaining words
  function automatic void compress_block();
    logic [31:0] w [64];
    logic [31:0] v [8];
    logic [31:0] s0, s1, t1, t2;
    int i;
    for (i = 0; i < 16; i++)
      w[i] = {blk_bytes[4*i], blk_bytes[4*i+1], blk_bytes[4*i+2], blk_bytes[4*i+3]};
    for (i = 16; i < 64; i++) begin
      s0 = ror32(w[i-15], 7) ^ ror32(w[i-15], 18) ^ (w[i-15] >> 3);
      s1 = ror32(w[i-2], 17) ^ ror32(w[i-2], 19) ^ (w[i-2] >> 10);
      w[i] = w[i-16] + s0 + w[i-7] + s1;
    end
    for (i = 0; i < 8; i++) v[i] = chain_h[i];
    for (i = 0; i < 64; i++) begin
      t1 = v[7] + (ror32(v[4], 6) ^ ror32(v[4], 11) ^ ror32(v[4], 25))
         + ((v[4] & v[5]) ^ (~v[4] & v[6])) + RK[i] + w[i];
      t2 = (ror32(v[0], 2) ^ ror32(v[0], 13) ^ ror32(v[0], 22))
         + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
      v[7] = v[6]; v[6] = v[5]; v[5] = v[4];
      v[4] = v[3] + t1;
      v[3] = v[2]; v[2] = v[1]; v[1] = v[0];
      v[0] = t1 + t2;
    end
    for (i = 0; i < 8; i++) chain_h[i] += v[i];
  endfunction

  // Absorb one accepted beat; a closing beat pads and queues the digest
  function automatic void absorb_beat(input logic [7:0] d, input logic hb, input logic lst);
    logic [63:0]  bit_len;
    digest_word_t dw;
    int i;
    if (hb) begin
      blk_bytes[blk_fill] = d;
      blk_fill++;
      msg_bytes++;
      if (blk_fill == BLOCK_BYTES) begin
        compress_block();
        blk_fill = 0;
      end
    end
    if (lst) begin
      bit_len = {msg_bytes, 3'b000};
      blk_bytes[blk_fill] = PAD_MARK;
      blk_fill++;
      // no room for the length: spill into a second block
      if (blk_fill > LEN_OFFSET) begin
        while (blk_fill < BLOCK_BYTES) begin
          blk_bytes[blk_fill] = 8'h00;
          blk_fill++;
        end
        compress_block();
        blk_fill = 0;
      end
      while (blk_fill < LEN_OFFSET) begin
        blk_bytes[blk_fill] = 8'h00;
        blk_fill++;
      end
      for (i = 0; i < 8; i++) blk_bytes[LEN_OFFSET + i] = bit_len[63 - 8*i -: 8];
      compress_block();
      for (i = 0; i < 8; i++) begin
        dw.word = chain_h[i];
        dw.index = 3'(i);
        dw.last_word = (i == 7);
        digest_q.push_back(dw);
      end
      hash_restart();
    end
  endfunction

  task automatic flag_mismatch(input string what, input logic [31:0] got,
                               input logic [31:0] want);
    $display("mismatch at %0t: %s got %h expected %h", $realtime, what, got, want);
    err_count++;
  endtask

  function automatic void add_beat(input logic [7:0] d, input logic hb, input logic lst,
                                   input logic drain);
    byte_beat_t b;
    b.data = d;
    b.has_byte = hb;
    b.last = lst;
    b.drain_first = drain;
    beat_q.push_back(b);
    real_beats++;
  endfunction

  // Random message of len bytes, with stray no-op beats mixed in
  function automatic void add_message(input int unsigned len, input logic drain);
    logic close_on_byte;
    int unsigned k;
    close_on_byte = (len > 0) && $urandom_range(0, 1);
    for (k = 0; k < len; k++) begin
      if ($urandom_range(0, 7) == 0) add_beat(8'($urandom), 1'b0, 1'b0, drain && k == 0);
      add_beat(8'($urandom), 1'b1, close_on_byte && (k == len - 1), drain && k == 0);
    end
    if (!close_on_byte) add_beat(8'($urandom), 1'b0, 1'b1, drain && len == 0);
    msg_count++;
  endfunction

  // Beat sampling, prediction and digest checking
  always @(posedge clk) begin : watch
    digest_word_t want;
    in_beat <= rst_n && in_valid && in_ready;
    out_beat <= rst_n && out_valid && out_ready;
    if (rst_n && in_valid && in_ready) absorb_beat(in_data_byte, in_has_byte, in_last);
    if (rst_n && out_valid && out_ready) begin
      words_seen <= words_seen + 1;
      if (digest_q.size() == 0) begin
        flag_mismatch("digest beat with none pending", out_digest_word, 32'h0);
      end else begin
        want = digest_q.pop_front();
        if (out_digest_word !== want.word)
          flag_mismatch("digest_word", out_digest_word, want.word);
        if (out_word_index !== want.index)
          flag_mismatch("word_index", 32'(out_word_index), 32'(want.index));
        if (out_last_word !== want.last_word)
          flag_mismatch("last_word", 32'(out_last_word), 32'(want.last_word));
      end
    end
  end

  // Sender: one beat in flight, random gap after each accepted beat
  always @(negedge clk) begin : drive
    byte_beat_t b;
    if (rst_n && !(in_valid && !in_beat)) begin
      if (in_beat) begin
        if (drv_burst > 0) begin
          drv_burst--;
          drv_gap = 0;
        end else if ($urandom_range(0, 15) == 0) begin
          drv_burst = $urandom_range(16, 40);
          drv_gap = 0;
        end else begin
          drv_gap = $urandom_range(0, 17);
        end
      end
      if (drv_gap > 0) begin
        drv_gap--;
        in_valid <= 1'b0;
      end else if (beat_q.size() > 0 && !(beat_q[0].drain_first && digest_q.size() > 0)) begin
        b = beat_q.pop_front();
        in_data_byte <= b.data;
        in_has_byte <= b.has_byte;
        in_last <= b.last;
        in_valid <= 1'b1;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Receiver: random stall per digest beat, plus one long hold-off
  always @(negedge clk) begin : receive
    if (rst_n) begin
      if (out_beat) begin
        if (words_seen == HOLD_AT_WORD && !long_hold_done) begin
          rcv_hold = LONG_HOLD;
          long_hold_done = 1'b1;
        end
        if (rcv_burst > 0) begin
          rcv_burst--;
          rcv_stall = 0;
        end else if ($urandom_range(0, 15) == 0) begin
          rcv_burst = $urandom_range(16, 40);
          rcv_stall = 0;
        end else begin
          rcv_stall = $urandom_range(0, 17);
        end
      end
      if (rcv_hold > 0) begin
        rcv_hold--;
        out_ready <= 1'b0;
      end else if (rcv_stall > 0) begin
        rcv_stall--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // Hang detection
  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("sha256_byte_stream_hasher_unit_tb: errors");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin : stimulus
    int unsigned edge_len [10];
    int unsigned len;
    int unsigned pick;
    edge_len = '{55, 56, 57, 63, 64, 65, 119, 120, 127, 128};
    hash_restart();

    // Directed: empty message, close on a byte, close without a byte, no-ops
    add_beat(8'hff, 1'b0, 1'b1, 1'b0);
    add_beat(8'h61, 1'b1, 1'b0, 1'b0);
    add_beat(8'h62, 1'b1, 1'b0, 1'b0);
    add_beat(8'h63, 1'b1, 1'b1, 1'b0);
    add_beat(8'ha5, 1'b0, 1'b0, 1'b0);
    add_beat(8'h00, 1'b1, 1'b0, 1'b0);
    add_beat(8'hff, 1'b1, 1'b0, 1'b0);
    add_beat(8'h5a, 1'b0, 1'b0, 1'b0);
    add_beat(8'h3c, 1'b0, 1'b1, 1'b0);
    add_beat(8'h80, 1'b1, 1'b1, 1'b0);
    add_beat(8'h00, 1'b0, 1'b1, 1'b1);
    real_beats = 0;

    // Random messages, padding boundaries well represented
    while (real_beats < RAND_BEATS) begin
      pick = $urandom_range(0, 9);
      if (pick < 5) len = $urandom_range(0, 12);
      else if (pick < 8) len = edge_len[$urandom_range(0, 9)];
      else len = $urandom_range(0, 140);
      add_message(len, (msg_count % 7) == 2);
    end

    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    @(posedge clk);
    while (beat_q.size() > 0 || in_valid || digest_q.size() > 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (digest_q.size() > 0)
      flag_mismatch("digest words never returned", 32'(digest_q.size()), 32'h0);
    if (err_count == 0) begin
      $display("sha256_byte_stream_hasher_unit_tb: clean");
    end else begin
      $display("sha256_byte_stream_hasher_unit_tb: errors");
    end
    $finish;
  end

endmodule
